// File: design/rar_pkg.sv
package rar_pkg;

	// width of every numerator and denominator field on the ports
	localparam int DATA_BITS = 32;
	localparam int CMD_BITS  = 3;

	// command codes
	localparam logic [CMD_BITS-1:0] CMD_ADD    = 3'd0;
	localparam logic [CMD_BITS-1:0] CMD_SUB    = 3'd1;
	localparam logic [CMD_BITS-1:0] CMD_MUL    = 3'd2;
	localparam logic [CMD_BITS-1:0] CMD_DIV    = 3'd3;
	localparam logic [CMD_BITS-1:0] CMD_REDUCE = 3'd4;

	// operand pair for the shared multiplier
	typedef enum logic [2:0] {
		MUL_AN_BD,
		MUL_BN_AD,
		MUL_AD_BD,
		MUL_AN_BN,
		MUL_AD_BN
	} mul_sel_t;

	// numerator register update
	typedef enum logic [2:0] {
		N_HOLD,
		N_LOAD,
		N_ADD,
		N_SUB,
		N_SPECIAL,
		N_QUOT
	} n_op_t;

	// denominator register update
	typedef enum logic [1:0] {
		D_HOLD,
		D_LOAD,
		D_SPECIAL,
		D_QUOT
	} d_op_t;

	// controller to datapath
	typedef struct packed {
		logic     load_in;
		mul_sel_t mul_sel;
		n_op_t    n_op;
		d_op_t    d_op;
		logic     gcd_init;
		logic     gcd_step;
		logic     div_init;
		logic     div_step;
		logic     out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [CMD_BITS-1:0] cmd;
		logic                a_num_zero;
		logic                a_den_zero;
		logic                gcd_done;
		logic                div_last;
	} dp_stat_t;

endpackage

// File: design/rar_if.sv
// input channel: command and two fractions
interface rar_in_if;
	logic                                   valid;
	logic                                   ready;
	logic        [rar_pkg::CMD_BITS-1:0]    command;
	logic signed [rar_pkg::DATA_BITS-1:0]   a_num;
	logic signed [rar_pkg::DATA_BITS-1:0]   a_den;
	logic signed [rar_pkg::DATA_BITS-1:0]   b_num;
	logic signed [rar_pkg::DATA_BITS-1:0]   b_den;

	modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

// output channel: result fraction and flags
interface rar_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [rar_pkg::DATA_BITS-1:0]   res_num;
	logic signed [rar_pkg::DATA_BITS-1:0]   res_den;
	logic                                   overflow;
	logic                                   zero_den;

	modport source (output valid, res_num, res_den, overflow, zero_den, input ready);
	modport sink (input valid, res_num, res_den, overflow, zero_den, output ready);
endinterface

// File: design/rar_datapath.sv
module rar_datapath #(
	parameter int WORD_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rar_pkg::dp_cmd_t                     ctl,
	output rar_pkg::dp_stat_t                    stat,
	input  logic        [rar_pkg::CMD_BITS-1:0]  in_command,
	input  logic signed [rar_pkg::DATA_BITS-1:0] in_a_num,
	input  logic signed [rar_pkg::DATA_BITS-1:0] in_a_den,
	input  logic signed [rar_pkg::DATA_BITS-1:0] in_b_num,
	input  logic signed [rar_pkg::DATA_BITS-1:0] in_b_den,
	output logic signed [rar_pkg::DATA_BITS-1:0] res_num,
	output logic signed [rar_pkg::DATA_BITS-1:0] res_den,
	output logic                                 overflow,
	output logic                                 zero_den
);

	localparam int W        = WORD_BITS;
	localparam int CNT_BITS = $clog2(WORD_BITS);

	// captured operands
	logic        [rar_pkg::CMD_BITS-1:0] cmd_q;
	logic signed [W-1:0]                 an_q, ad_q, bn_q, bd_q;

	// products and exact result
	logic signed [W-1:0]   mul_x, mul_y;
	logic signed [2*W-1:0] prod_q;
	logic signed [2*W:0]   n_q;
	logic signed [2*W-1:0] d_q;

	// gcd and divider registers
	logic [W-1:0]          u_q, v_q;
	logic [W-1:0]          nm_q, dm_q;
	logic [W-1:0]          rn_q, rd_q;
	logic [CNT_BITS-1:0]   cnt_q;

	// output word
	logic signed [rar_pkg::DATA_BITS-1:0] res_num_q, res_den_q;
	logic                                 overflow_q, zero_den_q;

	logic [W-1:0]          an_mag, ad_mag;
	logic                  an_zero, ad_zero;
	logic [W:0]            sub_uv;
	logic [W-1:0]          sub_vu;
	logic [W:0]            trial_n, trial_d, diff_n, diff_d;
	logic                  take_n, take_d;
	logic signed [2*W:0]   n_spec, n_quot;
	logic signed [2*W-1:0] d_spec, d_quot;
	logic                  special_den;
	logic [W+1:0]          n_top;
	logic [W:0]            d_top;
	logic signed [W-1:0]   num_w, den_w;

	// operand capture
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q <= in_command;
			an_q  <= in_a_num[W-1:0];
			ad_q  <= in_a_den[W-1:0];
			bn_q  <= in_b_num[W-1:0];
			bd_q  <= in_b_den[W-1:0];
		end
	end

	// shared multiplier operand select
	always_comb begin
		unique case (ctl.mul_sel)
			rar_pkg::MUL_AN_BD: begin mul_x = an_q; mul_y = bd_q; end
			rar_pkg::MUL_BN_AD: begin mul_x = bn_q; mul_y = ad_q; end
			rar_pkg::MUL_AD_BD: begin mul_x = ad_q; mul_y = bd_q; end
			rar_pkg::MUL_AN_BN: begin mul_x = an_q; mul_y = bn_q; end
			rar_pkg::MUL_AD_BN: begin mul_x = ad_q; mul_y = bn_q; end
			default:            begin mul_x = an_q; mul_y = bd_q; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_x * mul_y;
	end

	// magnitudes and zero checks of a
	assign an_mag  = an_q[W-1] ? W'(-an_q) : W'(an_q);
	assign ad_mag  = ad_q[W-1] ? W'(-ad_q) : W'(ad_q);
	assign an_zero = (an_q == '0);
	assign ad_zero = (ad_q == '0);

	// binary gcd subtractors
	assign sub_uv = {1'b0, u_q} - {1'b0, v_q};
	assign sub_vu = v_q - u_q;

	// restoring divider, numerator and denominator lanes
	assign trial_n = {rn_q, nm_q[W-1]};
	assign trial_d = {rd_q, dm_q[W-1]};
	assign diff_n  = trial_n - {1'b0, u_q};
	assign diff_d  = trial_d - {1'b0, u_q};
	assign take_n  = !diff_n[W];
	assign take_d  = !diff_d[W];

	// gcd search followed by division by its odd part
	always_ff @(posedge clk) begin
		if (ctl.gcd_init) begin
			u_q  <= an_mag;
			v_q  <= ad_mag;
			nm_q <= an_mag;
			dm_q <= ad_mag;
		end else if (ctl.gcd_step) begin
			priority if (!u_q[0] && !v_q[0]) begin
				// common factor two comes out of every value
				u_q  <= u_q >> 1;
				v_q  <= v_q >> 1;
				nm_q <= nm_q >> 1;
				dm_q <= dm_q >> 1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (!sub_uv[W]) begin
				u_q <= sub_uv[W:1];
			end else begin
				v_q <= sub_vu >> 1;
			end
		end else if (ctl.div_init) begin
			rn_q <= '0;
			rd_q <= '0;
		end else if (ctl.div_step) begin
			rn_q <= take_n ? diff_n[W-1:0] : trial_n[W-1:0];
			rd_q <= take_d ? diff_d[W-1:0] : trial_d[W-1:0];
			nm_q <= {nm_q[W-2:0], take_n};
			dm_q <= {dm_q[W-2:0], take_d};
		end
	end

	// divider step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.div_init) begin
			cnt_q <= '0;
		end else if (ctl.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// special results: zero numerator, zero denominator, unused codes
	assign special_den = (cmd_q == rar_pkg::CMD_REDUCE) && ad_zero;
	always_comb begin
		if (special_den && !an_zero) begin
			n_spec = an_q[W-1] ? -(2*W+1)'(1) : (2*W+1)'(1);
		end else begin
			n_spec = '0;
		end
	end
	assign d_spec = special_den ? '0 : (2*W)'(1);

	// reduced result from the quotients
	assign n_quot = (an_q[W-1] ^ ad_q[W-1]) ? -$signed({{(W+1){1'b0}}, nm_q})
	                                        : $signed({{(W+1){1'b0}}, nm_q});
	assign d_quot = $signed({{W{1'b0}}, dm_q});

	// exact numerator and denominator
	always_ff @(posedge clk) begin
		unique case (ctl.n_op)
			rar_pkg::N_HOLD:    n_q <= n_q;
			rar_pkg::N_LOAD:    n_q <= (2*W+1)'(prod_q);
			rar_pkg::N_ADD:     n_q <= n_q + (2*W+1)'(prod_q);
			rar_pkg::N_SUB:     n_q <= n_q - (2*W+1)'(prod_q);
			rar_pkg::N_SPECIAL: n_q <= n_spec;
			rar_pkg::N_QUOT:    n_q <= n_quot;
			default:            n_q <= n_q;
		endcase
		unique case (ctl.d_op)
			rar_pkg::D_HOLD:    d_q <= d_q;
			rar_pkg::D_LOAD:    d_q <= prod_q;
			rar_pkg::D_SPECIAL: d_q <= d_spec;
			rar_pkg::D_QUOT:    d_q <= d_quot;
			default:            d_q <= d_q;
		endcase
	end

	// wrap and range checks
	assign n_top = n_q[2*W:W-1];
	assign d_top = d_q[2*W-1:W-1];
	assign num_w = n_q[W-1:0];
	assign den_w = d_q[W-1:0];

	// output word register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			res_num_q  <= rar_pkg::DATA_BITS'(num_w);
			res_den_q  <= rar_pkg::DATA_BITS'(den_w);
			overflow_q <= !((&n_top) || !(|n_top)) || !((&d_top) || !(|d_top));
			zero_den_q <= (den_w == '0);
		end
	end

	assign res_num  = res_num_q;
	assign res_den  = res_den_q;
	assign overflow = overflow_q;
	assign zero_den = zero_den_q;

	// status back to the controller
	assign stat.cmd        = cmd_q;
	assign stat.a_num_zero = an_zero;
	assign stat.a_den_zero = ad_zero;
	assign stat.gcd_done   = (u_q == v_q);
	assign stat.div_last   = (cnt_q == CNT_BITS'(W - 1));

endmodule

// File: design/rar_ctrl.sv
module rar_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  rar_pkg::dp_stat_t  stat,
	output rar_pkg::dp_cmd_t   ctl
);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_DECODE = 11'b000_0000_0010,
		ST_M0     = 11'b000_0000_0100,
		ST_M1     = 11'b000_0000_1000,
		ST_M2     = 11'b000_0001_0000,
		ST_M3     = 11'b000_0010_0000,
		ST_SPEC   = 11'b000_0100_0000,
		ST_GCD    = 11'b000_1000_0000,
		ST_DIV    = 11'b001_0000_0000,
		ST_QUOT   = 11'b010_0000_0000,
		ST_FIN    = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_fire;
	logic   is_addsub, is_arith;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign is_addsub = (stat.cmd == rar_pkg::CMD_ADD) || (stat.cmd == rar_pkg::CMD_SUB);
	assign is_arith  = is_addsub || (stat.cmd == rar_pkg::CMD_MUL) ||
	                   (stat.cmd == rar_pkg::CMD_DIV);

	// sequencing and datapath commands
	always_comb begin
		state_d      = state_q;
		ctl          = '0;
		ctl.mul_sel  = rar_pkg::MUL_AN_BD;
		ctl.n_op     = rar_pkg::N_HOLD;
		ctl.d_op     = rar_pkg::D_HOLD;
		ctl.load_in  = in_fire;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (is_arith) begin
					state_d = ST_M0;
				end else if ((stat.cmd == rar_pkg::CMD_REDUCE) && !stat.a_num_zero &&
				             !stat.a_den_zero) begin
					ctl.gcd_init = 1'b1;
					state_d      = ST_GCD;
				end else begin
					state_d = ST_SPEC;
				end
			end
			ST_M0: begin
				ctl.mul_sel = (stat.cmd == rar_pkg::CMD_MUL) ? rar_pkg::MUL_AN_BN
				                                             : rar_pkg::MUL_AN_BD;
				state_d     = ST_M1;
			end
			ST_M1: begin
				if (is_addsub) begin
					ctl.mul_sel = rar_pkg::MUL_BN_AD;
					state_d     = ST_M2;
				end else begin
					ctl.mul_sel = (stat.cmd == rar_pkg::CMD_MUL) ? rar_pkg::MUL_AD_BD
					                                             : rar_pkg::MUL_AD_BN;
					state_d     = ST_M3;
				end
				ctl.n_op = rar_pkg::N_LOAD;
			end
			ST_M2: begin
				ctl.mul_sel = rar_pkg::MUL_AD_BD;
				ctl.n_op    = (stat.cmd == rar_pkg::CMD_SUB) ? rar_pkg::N_SUB : rar_pkg::N_ADD;
				state_d     = ST_M3;
			end
			ST_M3: begin
				ctl.d_op = rar_pkg::D_LOAD;
				state_d  = ST_FIN;
			end
			ST_SPEC: begin
				ctl.n_op = rar_pkg::N_SPECIAL;
				ctl.d_op = rar_pkg::D_SPECIAL;
				state_d  = ST_FIN;
			end
			ST_GCD: begin
				if (stat.gcd_done) begin
					ctl.div_init = 1'b1;
					state_d      = ST_DIV;
				end else begin
					ctl.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_QUOT;
				end
			end
			ST_QUOT: begin
				ctl.n_op = rar_pkg::N_QUOT;
				ctl.d_op = rar_pkg::D_QUOT;
				state_d  = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	// a waiting word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!out_valid_q || out_ready))
		else $error("output word overwritten");

	// an accepted word is decoded next
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_DECODE))
		else $error("accepted word not decoded");

	// no gcd step once both values agree
	a_gcd_stop: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.gcd_step |-> !stat.gcd_done)
		else $error("gcd stepped past its end");

	// last divider step hands over to the quotient load
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && stat.div_last) |=> (state_q == ST_QUOT))
		else $error("divider did not finish");
`endif

endmodule

// File: design/rational_arith_reduce_unit.sv
// channel  | role   | handshake     | word
// in_ch    | sink   | valid / ready | command, a_num, a_den, b_num, b_den
// out_ch   | source | valid / ready | res_num, res_den, overflow, zero_den
//
// one word at a time; add and subtract form three products on the shared multiplier,
// multiply and divide form two (a reduce with a zero field or an unused code uses none)
// reduce runs a binary gcd search of at most 2*WORD_BITS steps, then WORD_BITS
// steps of the two-lane restoring divider
// the next word is accepted while a finished result waits on out_ch
// arst_n clears the controller and the output valid; no clearing pass
module rational_arith_reduce_unit #(
	parameter int WORD_BITS = 32
) (
	input logic       clk,
	input logic       arst_n,
	rar_in_if.sink    in_ch,
	rar_out_if.source out_ch
);

	rar_pkg::dp_cmd_t  ctl;
	rar_pkg::dp_stat_t stat;

	// sequencer
	rar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// arithmetic and gcd datapath
	rar_datapath #(
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.in_command (in_ch.command),
		.in_a_num   (in_ch.a_num),
		.in_a_den   (in_ch.a_den),
		.in_b_num   (in_ch.b_num),
		.in_b_den   (in_ch.b_den),
		.res_num    (out_ch.res_num),
		.res_den    (out_ch.res_den),
		.overflow   (out_ch.overflow),
		.zero_den   (out_ch.zero_den)
	);

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int WORD_BITS       = 32;
	localparam int RANDOM_WORDS    = 630;
	localparam int TAIL_WORDS      = 80;
	localparam int PRESSURE_AT     = 60;
	localparam int PRESSURE_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int PRINT_LIMIT     = 40;

	localparam logic [rar_pkg::CMD_BITS-1:0] CMD_SPARE_FIRST = rar_pkg::CMD_REDUCE + 1'b1;
	localparam logic [rar_pkg::CMD_BITS-1:0] CMD_TOP         = '1;

	localparam logic signed [rar_pkg::DATA_BITS-1:0] W_MAX = 32'sh7fffffff;
	localparam logic signed [rar_pkg::DATA_BITS-1:0] W_MIN = 32'sh80000000;

	typedef struct packed {
		logic        [rar_pkg::CMD_BITS-1:0]  command;
		logic signed [rar_pkg::DATA_BITS-1:0] a_num;
		logic signed [rar_pkg::DATA_BITS-1:0] a_den;
		logic signed [rar_pkg::DATA_BITS-1:0] b_num;
		logic signed [rar_pkg::DATA_BITS-1:0] b_den;
	} frac_word_t;

	typedef struct packed {
		logic signed [rar_pkg::DATA_BITS-1:0] res_num;
		logic signed [rar_pkg::DATA_BITS-1:0] res_den;
		logic                                 overflow;
		logic                                 zero_den;
	} frac_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	rar_in_if  in_ch ();
	rar_out_if out_ch ();

	rational_arith_reduce_unit #(
		.WORD_BITS(WORD_BITS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	frac_word_t   pending_words[$];
	frac_result_t expected_results[$];
	frac_result_t head_result;

	int total_words;
	int words_accepted;
	int results_seen;
	int mismatch_count;
	int send_gap;
	int stall_left;
	int hold_left;
	bit pressure_done;
	int idle_cycles;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// operand value in the block's word, sign-extended
	function automatic longint to_word(logic [rar_pkg::DATA_BITS-1:0] f);
		logic signed [WORD_BITS-1:0] low;
		low = f[WORD_BITS-1:0];
		return low;
	endfunction

	// exact value wrapped to the word and sign-extended to the port
	function automatic logic signed [rar_pkg::DATA_BITS-1:0] wrap_out(logic signed [65:0] v);
		logic signed [WORD_BITS-1:0] low;
		low = v[WORD_BITS-1:0];
		return low;
	endfunction

	function automatic bit fits_word(logic signed [65:0] v);
		logic signed [65:0] hi;
		hi = (66'sd1 <<< (WORD_BITS - 1)) - 66'sd1;
		return (v <= hi) && (v >= -hi - 66'sd1);
	endfunction

	function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
		longint unsigned r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// expected result word for one command word
	function automatic frac_result_t predict_fraction(frac_word_t w);
		longint an, ad, bn, bd, n, d;
		longint unsigned g;
		logic signed [65:0] num_x, den_x;
		frac_result_t r;
		an = to_word(w.a_num);
		ad = to_word(w.a_den);
		bn = to_word(w.b_num);
		bd = to_word(w.b_den);
		num_x = 66'sd0;
		den_x = 66'sd1;
		case (w.command)
			rar_pkg::CMD_ADD: begin
				num_x = an * bd + bn * ad;
				den_x = ad * bd;
			end
			rar_pkg::CMD_SUB: begin
				num_x = an * bd - bn * ad;
				den_x = ad * bd;
			end
			rar_pkg::CMD_MUL: begin
				num_x = an * bn;
				den_x = ad * bd;
			end
			rar_pkg::CMD_DIV: begin
				num_x = an * bd;
				den_x = ad * bn;
			end
			rar_pkg::CMD_REDUCE: begin
				n = an;
				d = ad;
				if (d == 0) begin
					// zero denominator keeps only the sign of the numerator
					n = (n > 0) ? 1 : ((n < 0) ? -1 : 0);
				end else if (n == 0) begin
					d = 1;
				end else begin
					if (d < 0) begin
						n = -n;
						d = -d;
					end
					g = euclid_gcd((n < 0) ? -n : n, d);
					n = n / longint'(g);
					d = d / longint'(g);
				end
				num_x = n;
				den_x = d;
			end
			default: ;
		endcase
		r.res_num  = wrap_out(num_x);
		r.res_den  = wrap_out(den_x);
		r.overflow = !(fits_word(num_x) && fits_word(den_x));
		r.zero_den = (den_x[WORD_BITS-1:0] == '0);
		return r;
	endfunction

	// mix of small, extreme, power-of-two and full-range values
	function automatic logic signed [rar_pkg::DATA_BITS-1:0] pick_operand();
		logic signed [rar_pkg::DATA_BITS-1:0] v;
		case ($urandom_range(0, 5))
			0: v = int'($urandom_range(0, 200)) - 100;
			1: v = 32'sd1 <<< $urandom_range(0, rar_pkg::DATA_BITS - 1);
			2: begin
				case ($urandom_range(0, 5))
					0: v = 0;
					1: v = 1;
					2: v = -1;
					3: v = W_MIN;
					4: v = W_MAX;
					default: v = W_MIN + 1;
				endcase
			end
			3: v = int'($urandom_range(0, 65535));
			default: v = $urandom;
		endcase
		if ($urandom_range(0, 1) == 1 && v != W_MIN)
			v = -v;
		return v;
	endfunction

	task automatic queue_word(input logic [rar_pkg::CMD_BITS-1:0] cmd,
		input logic signed [31:0] an, input logic signed [31:0] ad,
		input logic signed [31:0] bn, input logic signed [31:0] bd);
		pending_words.push_back('{cmd, an, ad, bn, bd});
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
	endtask

	// input driver: one word from the pending queue at a time, random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid    <= 1'b0;
			in_ch.command  <= '0;
			in_ch.a_num    <= '0;
			in_ch.a_den    <= '0;
			in_ch.b_num    <= '0;
			in_ch.b_den    <= '0;
			send_gap       <= 0;
			words_accepted <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_results.push_back(predict_fraction('{in_ch.command, in_ch.a_num,
					in_ch.a_den, in_ch.b_num, in_ch.b_den}));
				words_accepted <= words_accepted + 1;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0) begin
					in_ch.valid <= 1'b0;
					send_gap    <= send_gap - 1;
				end else if (pending_words.size() > 0) begin
					in_ch.command <= pending_words[0].command;
					in_ch.a_num   <= pending_words[0].a_num;
					in_ch.a_den   <= pending_words[0].a_den;
					in_ch.b_num   <= pending_words[0].b_num;
					in_ch.b_den   <= pending_words[0].b_den;
					in_ch.valid   <= 1'b1;
					void'(pending_words.pop_front());
					if (words_accepted + TAIL_WORDS < total_words && $urandom_range(0, 5) == 0)
						send_gap <= $urandom_range(1, 11);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare against the oldest expectation, random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready  <= 1'b0;
			stall_left    <= 0;
			hold_left     <= 0;
			pressure_done <= 1'b0;
			results_seen  <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					flag_mismatch("result word with nothing expected, res_num",
						out_ch.res_num, '0);
				end else begin
					head_result = expected_results.pop_front();
					if (out_ch.res_num !== head_result.res_num)
						flag_mismatch("res_num", out_ch.res_num, head_result.res_num);
					if (out_ch.res_den !== head_result.res_den)
						flag_mismatch("res_den", out_ch.res_den, head_result.res_den);
					if (out_ch.overflow !== head_result.overflow)
						flag_mismatch("overflow", out_ch.overflow, head_result.overflow);
					if (out_ch.zero_den !== head_result.zero_den)
						flag_mismatch("zero_den", out_ch.zero_den, head_result.zero_den);
				end
			end
			// one long hold-off so the block backs up into its input
			if (!pressure_done && results_seen == PRESSURE_AT) begin
				pressure_done <= 1'b1;
				hold_left     <= PRESSURE_CYCLES;
				out_ch.ready  <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left    <= hold_left - 1;
				out_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left   <= stall_left - 1;
				out_ch.ready <= 1'b0;
			end else if (words_accepted + TAIL_WORDS < total_words && $urandom_range(0, 5) == 0) begin
				stall_left   <= $urandom_range(1, 11) - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// cycles in which no word moves on either channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		logic [rar_pkg::CMD_BITS-1:0] cmd;
		logic signed [rar_pkg::DATA_BITS-1:0] common, an, ad;

		// directed words: each operation, field extremes, special cases
		queue_word(rar_pkg::CMD_ADD, 1, 2, 1, 3);
		queue_word(rar_pkg::CMD_SUB, 1, 2, 1, 3);
		queue_word(rar_pkg::CMD_MUL, -3, 4, 5, -7);
		queue_word(rar_pkg::CMD_DIV, 2, 3, -4, 5);
		queue_word(rar_pkg::CMD_ADD, W_MIN, W_MIN, W_MIN, W_MIN);
		queue_word(rar_pkg::CMD_SUB, W_MIN, 1, W_MAX, 1);
		queue_word(rar_pkg::CMD_MUL, W_MAX, W_MAX, W_MAX, W_MAX);
		queue_word(rar_pkg::CMD_DIV, W_MIN, W_MAX, W_MIN, W_MIN);
		queue_word(rar_pkg::CMD_MUL, 1, 65536, 1, 65536);
		queue_word(rar_pkg::CMD_DIV, 5, 7, 0, 3);
		queue_word(rar_pkg::CMD_ADD, 1, 0, 1, 9);
		queue_word(rar_pkg::CMD_REDUCE, 6, -4, 0, 0);
		queue_word(rar_pkg::CMD_REDUCE, 0, 5, W_MAX, W_MIN);
		queue_word(rar_pkg::CMD_REDUCE, 0, -7, -1, -1);
		queue_word(rar_pkg::CMD_REDUCE, 5, 0, 0, 0);
		queue_word(rar_pkg::CMD_REDUCE, -5, 0, 0, 0);
		queue_word(rar_pkg::CMD_REDUCE, 0, 0, 0, 0);
		queue_word(rar_pkg::CMD_REDUCE, W_MIN, -1, 0, 0);
		queue_word(rar_pkg::CMD_REDUCE, 1, W_MIN, 0, 0);
		queue_word(rar_pkg::CMD_REDUCE, W_MIN, W_MIN, 0, 0);
		queue_word(rar_pkg::CMD_REDUCE, W_MAX, W_MAX, 0, 0);
		queue_word(rar_pkg::CMD_REDUCE, W_MAX, 1, 0, 0);
		queue_word(CMD_SPARE_FIRST, 3, 4, 5, 6);
		queue_word(CMD_SPARE_FIRST + 1'b1, W_MIN, W_MAX, -1, 0);
		queue_word(CMD_TOP, -1, -1, -1, -1);

		// random words, reduce mostly on fractions with a real common factor
		repeat (RANDOM_WORDS) begin
			case ($urandom_range(0, 15))
				0, 1, 2: cmd = rar_pkg::CMD_ADD;
				3, 4, 5: cmd = rar_pkg::CMD_SUB;
				6, 7, 8: cmd = rar_pkg::CMD_MUL;
				9, 10, 11: cmd = rar_pkg::CMD_DIV;
				15: cmd = rar_pkg::CMD_BITS'($urandom_range(CMD_SPARE_FIRST, CMD_TOP));
				default: cmd = rar_pkg::CMD_REDUCE;
			endcase
			if (cmd == rar_pkg::CMD_REDUCE && $urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 1) == 1)
					common = int'($urandom_range(1, 3000));
				else
					common = 32'sd1 <<< $urandom_range(0, 12);
				an = common * (int'($urandom_range(0, 6000)) - 3000);
				ad = common * (int'($urandom_range(0, 6000)) - 3000);
				queue_word(cmd, an, ad, $urandom, $urandom);
			end else begin
				queue_word(cmd, pick_operand(), pick_operand(), pick_operand(), pick_operand());
			end
		end
		total_words = pending_words.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_accepted < total_words)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_results.size() != 0)
			$display("%0d expected results never arrived", expected_results.size());
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: files.f
design/rar_pkg.sv
design/rar_if.sv
design/rar_datapath.sv
design/rar_ctrl.sv
design/rational_arith_reduce_unit.sv
tb/tb_top.sv
